### sv/lbs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared constants and types for the linear blend skinning block.
// ----------------------------------------------------------------------------
package lbs_pkg;
    localparam int MAX_BONES  = 256;
    localparam int INFLUENCES = 4;
    localparam int SLOTS      = 12;
    localparam int BONE_W     = 8;
    localparam int SLOT_W     = 4;
    localparam int ADDR_W     = 12;
    localparam int TERM_W     = 50;
    localparam int WTERM_W    = 67;
    localparam int ACC_W      = 69;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_SKIN = 1'b1;

    typedef struct packed {
        logic signed [TERM_W-1:0] p0;
        logic signed [TERM_W-1:0] p1;
        logic signed [TERM_W-1:0] p2;
        logic signed [TERM_W-1:0] n0;
        logic signed [TERM_W-1:0] n1;
        logic signed [TERM_W-1:0] n2;
    } lane_vec_t;

    typedef struct packed {
        logic signed [WTERM_W-1:0] p0;
        logic signed [WTERM_W-1:0] p1;
        logic signed [WTERM_W-1:0] p2;
        logic signed [WTERM_W-1:0] n0;
        logic signed [WTERM_W-1:0] n1;
        logic signed [WTERM_W-1:0] n2;
    } lane_out_t;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
    } vtx_t;

    typedef struct packed {
        logic            wen;
        logic [ADDR_W-1:0] waddr;
        logic [31:0]     wdata;
    } load_t;
endpackage
`default_nettype wire

### sv/linear_blend_vertex_skinning.sv
`default_nettype none
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning
// Four-influence fixed point vertex skinning with replicated matrix banks.
// ----------------------------------------------------------------------------
// Registers to m_axis: bank read, product, transform, weight, sum, output.
// Throughput: one item per cycle unless stalled; lanes read own matrix banks.
// The pipeline stalls as a whole only when the output register is held.
// Reset clears the valid bits; matrix banks are undefined until loaded.
module linear_blend_vertex_skinning
    import lbs_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: load_bone, load_slot, load_value, pos_x, pos_y, pos_z,
    //        nrm_x, nrm_y, nrm_z, influence_bones, influence_weights, pad
    input  wire logic [335:0] s_axis_tdata,
    // tuser: cmd
    input  wire logic         s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: skin_pos_x, skin_pos_y, skin_pos_z, skin_nrm_x, skin_nrm_y,
    //        skin_nrm_z, saturated, pad
    output logic [199:0]      m_axis_tdata
);
    localparam int DEPTH = 5;

    logic      [DEPTH-1:0] vld_reg;
    logic                  adv;
    logic                  acc;
    load_t                 load;
    vtx_t                  vin;
    vtx_t                  vout;
    logic                  sat;
    lane_out_t             lanes [0:INFLUENCES-1];
    logic [192:0]          out_reg;
    logic                  ovld_reg;

    assign adv = !ovld_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign acc = s_axis_tvalid && adv;

    assign load.wen   = acc && (s_axis_tuser == CMD_LOAD)
                        && (s_axis_tdata[11:8] < SLOT_W'(SLOTS));
    assign load.waddr = s_axis_tdata[11:0];
    assign load.wdata = s_axis_tdata[43:12];

    assign vin.px = s_axis_tdata[75:44];
    assign vin.py = s_axis_tdata[107:76];
    assign vin.pz = s_axis_tdata[139:108];
    assign vin.nx = s_axis_tdata[171:140];
    assign vin.ny = s_axis_tdata[203:172];
    assign vin.nz = s_axis_tdata[235:204];

    genvar g;
    generate
        for (g = 0; g < INFLUENCES; g++)
        begin : g_lane
            lbs_lane u_lane (
                .clk    (clk),
                .rst_n  (rst_n),
                .load   (load),
                .adv    (adv),
                .bone   (s_axis_tdata[236+8*g +: 8]),
                .weight (s_axis_tdata[268+16*g +: 16]),
                .vtx    (vin),
                .result (lanes[g])
            );
        end
    endgenerate

    lbs_merge u_merge (
        .clk   (clk),
        .adv   (adv),
        .lanes (lanes),
        .vtx   (vout),
        .sat   (sat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            ovld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg  <= {vld_reg[DEPTH-2:0], acc && (s_axis_tuser == CMD_SKIN)};
            ovld_reg <= vld_reg[DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= {sat, vout.nz, vout.ny, vout.nx, vout.pz, vout.py, vout.px};
        end
    end

    assign m_axis_tvalid = ovld_reg;
    assign m_axis_tdata  = {7'd0, out_reg};

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow the output stage");
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        load.wen |-> acc && s_axis_tuser == CMD_LOAD)
        else $error("bank write without a load item");
endmodule
`default_nettype wire

### sv/lbs_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbs_lane
// One influence lane: own matrix bank, 3x4 transform, weight multiply.
// ----------------------------------------------------------------------------
module lbs_lane
    import lbs_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire load_t           load,
    input  wire logic            adv,
    input  wire logic [BONE_W-1:0] bone,
    input  wire logic [15:0]     weight,
    input  wire vtx_t            vtx,
    output lane_out_t            result
);
    logic signed [31:0] m_rd [0:SLOTS-1];
    vtx_t        v1_reg;
    logic [15:0] w1_reg;
    logic signed [63:0] prod_p_reg [0:8];
    logic signed [63:0] prod_n_reg [0:8];
    logic signed [TERM_W-1:0] tr_reg [0:2];
    logic [15:0] w2_reg;
    logic [15:0] w3_reg;
    lane_vec_t   t_reg;
    lane_out_t   out_reg;
    logic signed [31:0] pv [0:2];
    logic signed [31:0] nv [0:2];

    // One bank per matrix element, so each bank is read at a single address.
    genvar s;
    generate
        for (s = 0; s < SLOTS; s++)
        begin : g_bank
            logic [31:0]        bank_mem [0:MAX_BONES-1];
            logic signed [31:0] rd_reg;

            always_ff @(posedge clk)
            begin
                if (load.wen && (load.waddr[ADDR_W-1:BONE_W] == SLOT_W'(s)))
                begin
                    bank_mem[load.waddr[BONE_W-1:0]] <= load.wdata;
                end
                if (adv)
                begin
                    rd_reg <= bank_mem[bone];
                end
            end

            assign m_rd[s] = rd_reg;
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v1_reg <= vtx;
            w1_reg <= weight;
        end
    end

    assign pv[0] = v1_reg.px;
    assign pv[1] = v1_reg.py;
    assign pv[2] = v1_reg.pz;
    assign nv[0] = v1_reg.nx;
    assign nv[1] = v1_reg.ny;
    assign nv[2] = v1_reg.nz;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_p_reg[r*3+c] <= 64'(m_rd[r*4+c]) * 64'(pv[c]);
                    prod_n_reg[r*3+c] <= 64'(m_rd[r*4+c]) * 64'(nv[c]);
                end
                tr_reg[r] <= TERM_W'(m_rd[r*4+3] >>> 8);
            end
            w2_reg <= w1_reg;
            w3_reg <= w2_reg;
            t_reg.p0 <= tr_reg[0] + TERM_W'(prod_p_reg[0] >>> 24)
                + TERM_W'(prod_p_reg[1] >>> 24) + TERM_W'(prod_p_reg[2] >>> 24);
            t_reg.p1 <= tr_reg[1] + TERM_W'(prod_p_reg[3] >>> 24)
                + TERM_W'(prod_p_reg[4] >>> 24) + TERM_W'(prod_p_reg[5] >>> 24);
            t_reg.p2 <= tr_reg[2] + TERM_W'(prod_p_reg[6] >>> 24)
                + TERM_W'(prod_p_reg[7] >>> 24) + TERM_W'(prod_p_reg[8] >>> 24);
            t_reg.n0 <= TERM_W'(prod_n_reg[0] >>> 24) + TERM_W'(prod_n_reg[1] >>> 24)
                + TERM_W'(prod_n_reg[2] >>> 24);
            t_reg.n1 <= TERM_W'(prod_n_reg[3] >>> 24) + TERM_W'(prod_n_reg[4] >>> 24)
                + TERM_W'(prod_n_reg[5] >>> 24);
            t_reg.n2 <= TERM_W'(prod_n_reg[6] >>> 24) + TERM_W'(prod_n_reg[7] >>> 24)
                + TERM_W'(prod_n_reg[8] >>> 24);
            out_reg.p0 <= WTERM_W'(t_reg.p0) * $signed({1'b0, w3_reg});
            out_reg.p1 <= WTERM_W'(t_reg.p1) * $signed({1'b0, w3_reg});
            out_reg.p2 <= WTERM_W'(t_reg.p2) * $signed({1'b0, w3_reg});
            out_reg.n0 <= WTERM_W'(t_reg.n0) * $signed({1'b0, w3_reg});
            out_reg.n1 <= WTERM_W'(t_reg.n1) * $signed({1'b0, w3_reg});
            out_reg.n2 <= WTERM_W'(t_reg.n2) * $signed({1'b0, w3_reg});
        end
    end

    assign result = out_reg;

    logic unused_rst;
    assign unused_rst = rst_n;
endmodule
`default_nettype wire

### sv/lbs_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbs_merge
// Sums the weighted lanes, rounds to Q16.16 and saturates.
// ----------------------------------------------------------------------------
module lbs_merge
    import lbs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      adv,
    input  wire lane_out_t lanes [0:INFLUENCES-1],
    output vtx_t           vtx,
    output logic           sat
);
    logic signed [ACC_W-1:0] acc_reg [0:5];
    logic signed [ACC_W-1:0] sh [0:5];
    logic [31:0] res [0:5];
    logic [5:0]  clip;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            acc_reg[0] <= ACC_W'(lanes[0].p0) + ACC_W'(lanes[1].p0)
                + ACC_W'(lanes[2].p0) + ACC_W'(lanes[3].p0);
            acc_reg[1] <= ACC_W'(lanes[0].p1) + ACC_W'(lanes[1].p1)
                + ACC_W'(lanes[2].p1) + ACC_W'(lanes[3].p1);
            acc_reg[2] <= ACC_W'(lanes[0].p2) + ACC_W'(lanes[1].p2)
                + ACC_W'(lanes[2].p2) + ACC_W'(lanes[3].p2);
            acc_reg[3] <= ACC_W'(lanes[0].n0) + ACC_W'(lanes[1].n0)
                + ACC_W'(lanes[2].n0) + ACC_W'(lanes[3].n0);
            acc_reg[4] <= ACC_W'(lanes[0].n1) + ACC_W'(lanes[1].n1)
                + ACC_W'(lanes[2].n1) + ACC_W'(lanes[3].n1);
            acc_reg[5] <= ACC_W'(lanes[0].n2) + ACC_W'(lanes[1].n2)
                + ACC_W'(lanes[2].n2) + ACC_W'(lanes[3].n2);
        end
    end

    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            sh[k] = (acc_reg[k] + ACC_W'(1 << 14)) >>> 15;
            if (sh[k] > ACC_W'(64'sh7FFFFFFF))
            begin
                res[k]  = 32'h7FFFFFFF;
                clip[k] = 1'b1;
            end
            else if (sh[k] < -ACC_W'(64'sh80000000))
            begin
                res[k]  = 32'h80000000;
                clip[k] = 1'b1;
            end
            else
            begin
                res[k]  = sh[k][31:0];
                clip[k] = 1'b0;
            end
        end
    end

    assign vtx.px = res[0];
    assign vtx.py = res[1];
    assign vtx.pz = res[2];
    assign vtx.nx = res[3];
    assign vtx.ny = res[4];
    assign vtx.nz = res[5];
    assign sat    = |clip;
endmodule
`default_nettype wire
